/* src/line_edit_gap_buffer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the line editor
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_EDIT_GAP_BUFFER_ASSERT_SVH
`define LINE_EDIT_GAP_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define LEGB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("line editor assertion failed");
// Condition must never be seen outside reset.
`define LEGB_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("line editor forbidden condition");
`else
`define LEGB_ASSERT(lbl, clk, rst, prop)
`define LEGB_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* src/legb_pkg.sv */
// ----------------------------------------------------------------------------
// Line editor package
// Payload structs, event and character codes, internal command format.
// ----------------------------------------------------------------------------
package legb_pkg;

  // Input event and output character payloads
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
  } key_t;

  typedef struct packed {
    logic [7:0] line_char;
    logic       last_char;
  } line_t;

  // Event kinds
  localparam logic [1:0] EV_CHAR   = 2'd0;
  localparam logic [1:0] EV_DELETE = 2'd1;
  localparam logic [1:0] EV_LEFT   = 2'd2;
  localparam logic [1:0] EV_RIGHT  = 2'd3;

  // Control characters
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_ESCAPE    = 8'd27;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;

  // Back-end operation codes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_BKSP   = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_LEFT   = 3'd3;
  localparam logic [2:0] OP_RIGHT  = 3'd4;
  localparam logic [2:0] OP_EMIT   = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
  } cmd_t;

  // Front to queue write port
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

endpackage

/* src/line_edit_gap_buffer.sv */
// ----------------------------------------------------------------------------
// One-line text editor, gap buffer
// Key events in, emitted line characters out.
// ----------------------------------------------------------------------------
// Key channel (key_valid / key_stall / key): one transfer per event, mode
// selects character, delete, left or right. A character transfer with
// carriage return emits the line; escape is dropped at the front end.
// Line channel (line_valid / line_stall / line): one transfer per emitted
// character, left to right, last_char set on the final one. An empty line
// emits nothing.
// Events pass through a two-entry command queue, so the key side keeps
// taking events while the back end works or the line side stalls.
// Edits finish in the back end without a wait state; a cursor move does a
// registered store read, then the write into the other store (ST_MOVE). An
// emit does one store read per cycle into the output register, limited by
// the registered read port; line_stall holds the output register and pauses
// the reads without losing data.
// Reset (rst, synchronous) empties the line and the queue; the stores
// themselves are not cleared, nothing unwritten is ever read.
// ----------------------------------------------------------------------------
`include "line_edit_gap_buffer_assert.svh"

module line_edit_gap_buffer #(
  parameter int LINE_CAP = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            key_valid,
  output logic            key_stall,
  input  legb_pkg::key_t  key,
  output logic            line_valid,
  input  logic            line_stall,
  output legb_pkg::line_t line
);
  import legb_pkg::*;

  push_t wr;
  logic  q_full;
  logic  cmd_valid;
  cmd_t  cmd;
  logic  pop;

  // classify events
  legb_front u_front (
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key       (key),
    .q_full    (q_full),
    .wr        (wr)
  );

  // decouple front and back
  legb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .full      (q_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop)
  );

  // gap buffer and emit sequencer
  legb_back #(
    .LINE_CAP (LINE_CAP)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .pop        (pop),
    .line_valid (line_valid),
    .line_stall (line_stall),
    .line       (line)
  );

  // a transfer into the queue only happens when it has room
  `LEGB_NEVER(a_push_full, clk, rst, wr.push && q_full)
  // popping needs a queued command
  `LEGB_NEVER(a_pop_empty, clk, rst, pop && !cmd_valid)
  // a stalled output keeps its valid
  `LEGB_ASSERT(a_out_hold, clk, rst, (line_valid && line_stall) |=> line_valid)

endmodule

/* src/legb_front.sv */
// ----------------------------------------------------------------------------
// Line editor front end
// Accepts key events and turns them into back-end commands.
// ----------------------------------------------------------------------------
module legb_front (
  input  logic          key_valid,
  output logic          key_stall,
  input  legb_pkg::key_t key,
  input  logic          q_full,
  output legb_pkg::push_t wr
);
  import legb_pkg::*;

  logic keep;
  logic [2:0] op;

  // Escape is consumed here and never reaches the queue
  always_comb begin
    keep = 1'b1;
    op   = OP_INSERT;
    unique case (key.mode)
      EV_CHAR: begin
        if (key.char_code == CH_RETURN) begin
          op = OP_EMIT;
        end else if (key.char_code == CH_ESCAPE) begin
          keep = 1'b0;
        end else if (key.char_code == CH_BACKSPACE) begin
          op = OP_BKSP;
        end else begin
          op = OP_INSERT;
        end
      end
      EV_DELETE: op = OP_DELETE;
      EV_LEFT:   op = OP_LEFT;
      EV_RIGHT:  op = OP_RIGHT;
      default:   op = OP_INSERT;
    endcase
  end

  assign key_stall  = q_full;
  assign wr.push    = key_valid && !q_full && keep;
  assign wr.cmd.op  = op;
  assign wr.cmd.ch  = key.char_code;

endmodule

/* src/legb_queue.sv */
// ----------------------------------------------------------------------------
// Line editor command queue
// Small FIFO decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module legb_queue (
  input  logic            clk,
  input  logic            rst,
  input  legb_pkg::push_t wr,
  output logic            full,
  output logic            cmd_valid,
  output legb_pkg::cmd_t  cmd,
  input  logic            pop
);
  import legb_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W+1)'(QDEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr.push) begin
      slots[wptr] <= wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr.push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({wr.push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/legb_back.sv */
// ----------------------------------------------------------------------------
// Line editor back end
// Gap buffer stores, cursor counts and the line emit sequencer.
// ----------------------------------------------------------------------------
`include "line_edit_gap_buffer_assert.svh"

module legb_back #(
  parameter int LINE_CAP = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  legb_pkg::cmd_t  cmd,
  output logic            pop,
  output logic            line_valid,
  input  logic            line_stall,
  output legb_pkg::line_t line
);
  import legb_pkg::*;

  localparam int CNT_W = $clog2(LINE_CAP + 1);
  localparam int IDX_W = $clog2(LINE_CAP);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EMIT = 2'd1;
  localparam logic [1:0] ST_MOVE = 2'd2;

  logic [7:0] left_mem  [LINE_CAP];
  logic [7:0] right_mem [LINE_CAP];
  logic [7:0] left_rdata;
  logic [7:0] right_rdata;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] lc, lc_next;
  logic [CNT_W-1:0] rc, rc_next;
  logic [CNT_W-1:0] k, k_next;
  logic [CNT_W-1:0] total, total_next;
  logic             move_left, move_left_next;
  logic             rd_pend;
  logic             pend_sel, pend_sel_next;
  logic             pend_last, pend_last_next;
  logic             issue;
  logic             load_out;

  logic             left_we, left_re, right_we, right_re;
  logic [IDX_W-1:0] left_wa, left_ra, right_wa, right_ra;
  logic [7:0]       left_wd, right_wd;
  logic [CNT_W-1:0] sum;
  logic [CNT_W-1:0] rev_idx;

  assign sum      = lc + rc;
  assign rev_idx  = total - CNT_W'(1) - k;
  assign load_out = rd_pend && (!line_valid || !line_stall);

  always_comb begin
    pop            = 1'b0;
    issue          = 1'b0;
    state_next     = state;
    lc_next        = lc;
    rc_next        = rc;
    k_next         = k;
    total_next     = total;
    move_left_next = move_left;
    pend_sel_next  = pend_sel;
    pend_last_next = pend_last;
    left_we        = 1'b0;
    left_wa        = lc[IDX_W-1:0];
    left_wd        = cmd.ch;
    left_re        = 1'b0;
    left_ra        = k[IDX_W-1:0];
    right_we       = 1'b0;
    right_wa       = rc[IDX_W-1:0];
    right_wd       = left_rdata;
    right_re       = 1'b0;
    right_ra       = rev_idx[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        // wait for the last emit read to drain so read data stays intact
        if (cmd_valid && !rd_pend) begin
          pop = 1'b1;
          unique case (cmd.op)
            OP_INSERT: begin
              if (sum < CNT_W'(LINE_CAP)) begin
                left_we = 1'b1;
                lc_next = lc + 1'b1;
              end
            end
            OP_BKSP: begin
              if (lc != '0) lc_next = lc - 1'b1;
            end
            OP_DELETE: begin
              if (rc != '0) rc_next = rc - 1'b1;
            end
            OP_LEFT: begin
              if (lc != '0) begin
                left_re        = 1'b1;
                left_ra        = IDX_W'(lc - 1'b1);
                lc_next        = lc - 1'b1;
                move_left_next = 1'b1;
                state_next     = ST_MOVE;
              end
            end
            OP_RIGHT: begin
              if (rc != '0) begin
                right_re       = 1'b1;
                right_ra       = IDX_W'(rc - 1'b1);
                rc_next        = rc - 1'b1;
                move_left_next = 1'b0;
                state_next     = ST_MOVE;
              end
            end
            OP_EMIT: begin
              if (sum != '0) begin
                k_next     = '0;
                total_next = sum;
                state_next = ST_EMIT;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      ST_EMIT: begin
        if (!rd_pend || load_out) begin
          issue          = 1'b1;
          pend_sel_next  = !(k < lc);
          pend_last_next = (k == total - CNT_W'(1));
          if (k < lc) begin
            left_re = 1'b1;
          end else begin
            right_re = 1'b1;
          end
          k_next = k + 1'b1;
          if (k == total - CNT_W'(1)) state_next = ST_IDLE;
        end
      end
      ST_MOVE: begin
        // second half of a cursor move: write the character read last cycle
        if (move_left) begin
          right_we = 1'b1;
          right_wd = left_rdata;
          rc_next  = rc + 1'b1;
        end else begin
          left_we = 1'b1;
          left_wd = right_rdata;
          lc_next = lc + 1'b1;
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Stores: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (left_we) left_mem[left_wa] <= left_wd;
    if (left_re) left_rdata <= left_mem[left_ra];
  end

  always_ff @(posedge clk) begin
    if (right_we) right_mem[right_wa] <= right_wd;
    if (right_re) right_rdata <= right_mem[right_ra];
  end

  always_ff @(posedge clk) begin
    k         <= k_next;
    total     <= total_next;
    move_left <= move_left_next;
    pend_sel  <= pend_sel_next;
    pend_last <= pend_last_next;
    if (load_out) begin
      line.line_char <= pend_sel ? right_rdata : left_rdata;
      line.last_char <= pend_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      lc         <= '0;
      rc         <= '0;
      rd_pend    <= 1'b0;
      line_valid <= 1'b0;
    end else begin
      state      <= state_next;
      lc         <= lc_next;
      rc         <= rc_next;
      rd_pend    <= issue || (rd_pend && !load_out);
      line_valid <= load_out || (line_valid && line_stall);
    end
  end

  `LEGB_ASSERT(a_cap, clk, rst,
    (({1'b0, lc} + {1'b0, rc}) <= (CNT_W+1)'(LINE_CAP)))
  `LEGB_NEVER(a_pop_pend, clk, rst, pop && rd_pend)
  `LEGB_NEVER(a_read_clobber, clk, rst, issue && rd_pend && !load_out)
  `LEGB_ASSERT(a_move_one, clk, rst, (state == ST_MOVE) |=> (state == ST_IDLE))

endmodule
